/* rtl/icmp_rm_pkg.sv */
// Package for the ICMP reply matcher: payload structs, register map,
// outcome codes and header offsets. No dependencies.
package icmp_rm_pkg;

  // One transfer on the input channel: one packet byte.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] now_ticks;
  } in_item_t;

  // One transfer on the result channel: the verdict for one packet.
  typedef struct packed {
    logic [1:0]  outcome;
    logic        reply_kind;
    logic [31:0] source_addr;
    logic [31:0] round_trip;
  } out_item_t;

  // Configuration as seen by the decoder.
  typedef struct packed {
    logic [15:0] expected_id;
    logic [15:0] expected_seq;
    logic [7:0]  echo_reply_type;
    logic [7:0]  time_exceeded_type;
    logic [31:0] send_time;
  } cfg_t;

  localparam int unsigned ADDR_W = 5;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_EXPECTED_ID   = 3'd0,
    REG_EXPECTED_SEQ  = 3'd1,
    REG_ECHO_TYPE     = 3'd2,
    REG_TE_TYPE       = 3'd3,
    REG_SEND_TIME     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OUTCOME_MATCH    = 2'd0,
    OUTCOME_SHORT    = 2'd1,
    OUTCOME_BAD_TYPE = 2'd2,
    OUTCOME_MISMATCH = 2'd3
  } outcome_t;

  localparam logic [7:0] TE_TYPE_RESET = 8'd11;

  // Byte offsets relative to the start of an ICMP header.
  localparam int unsigned OFS_ID_HI   = 4;
  localparam int unsigned OFS_ID_LO   = 5;
  localparam int unsigned OFS_SEQ_HI  = 6;
  localparam int unsigned OFS_SEQ_LO  = 7;
  localparam int unsigned ICMP_HDR_LEN = 8;

  // Outer source address occupies bytes 12 through 15.
  localparam int unsigned SRC_FIRST = 12;
  localparam int unsigned SRC_LAST  = 15;

endpackage

/* rtl/icmp_rm_cfg.sv */
// Configuration register file of the ICMP reply matcher on an APB-style port.
// Depends on icmp_rm_pkg.
module icmp_rm_cfg
  import icmp_rm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_EXPECTED_ID:  cfg_nxt.expected_id        = pwdata[15:0];
        REG_EXPECTED_SEQ: cfg_nxt.expected_seq       = pwdata[15:0];
        REG_ECHO_TYPE:    cfg_nxt.echo_reply_type    = pwdata[7:0];
        REG_TE_TYPE:      cfg_nxt.time_exceeded_type = pwdata[7:0];
        REG_SEND_TIME:    cfg_nxt.send_time          = pwdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EXPECTED_ID:  prdata = {16'd0, cfg_r.expected_id};
      REG_EXPECTED_SEQ: prdata = {16'd0, cfg_r.expected_seq};
      REG_ECHO_TYPE:    prdata = {24'd0, cfg_r.echo_reply_type};
      REG_TE_TYPE:      prdata = {24'd0, cfg_r.time_exceeded_type};
      REG_SEND_TIME:    prdata = cfg_r.send_time;
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id        <= 16'd0;
      cfg_r.expected_seq       <= 16'd0;
      cfg_r.echo_reply_type    <= 8'd0;
      cfg_r.time_exceeded_type <= TE_TYPE_RESET;
      cfg_r.send_time          <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/icmp_rm_core.sv */
// Per-byte packet decoder of the ICMP reply matcher: header tracking,
// field capture and the end-of-packet verdict. Depends on icmp_rm_pkg.
module icmp_rm_core
  import icmp_rm_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  localparam int unsigned IDX_W = $clog2(MAX_PACKET_BYTES + 1);
  // One extra bit so header offsets added to a position never wrap.
  localparam int unsigned CW = IDX_W + 1;

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [5:0]       outer_len_r, outer_len_nxt;
  logic [7:0]       icmp_kind_r, icmp_kind_nxt;
  logic [5:0]       inner_len_r, inner_len_nxt;
  logic [15:0]      seen_id_r, seen_id_nxt;
  logic [15:0]      seen_seq_r, seen_seq_nxt;
  logic [31:0]      src_r, src_nxt;
  logic             found_r, found_nxt;

  logic [IDX_W-1:0] count;
  logic [CW-1:0]    pos, len, inner_start, base, rel;
  logic             take, past_hdr, is_echo, is_te, fld_en;
  logic             fin_echo, fin_te;
  logic [7:0]       b;

  assign b    = item.data_byte;
  assign take = byte_index_r < IDX_W'(MAX_PACKET_BYTES);
  assign pos  = {1'b0, byte_index_r};

  always_comb begin
    outer_len_nxt = outer_len_r;
    icmp_kind_nxt = icmp_kind_r;
    inner_len_nxt = inner_len_r;
    seen_id_nxt   = seen_id_r;
    seen_seq_nxt  = seen_seq_r;
    src_nxt       = src_r;
    found_nxt     = found_r;
    count         = byte_index_r;
    inner_start   = '0;
    base          = '0;
    rel           = '0;
    past_hdr      = 1'b0;
    fld_en        = 1'b0;
    is_echo       = icmp_kind_r == cfg.echo_reply_type;
    is_te         = icmp_kind_r == cfg.time_exceeded_type;

    if (take) begin
      count = byte_index_r + 1'b1;
      if (pos == '0) begin
        outer_len_nxt = {b[3:0], 2'b00};
      end
      if (pos >= CW'(SRC_FIRST) && pos <= CW'(SRC_LAST)) begin
        case (pos[1:0])
          2'd0:    src_nxt[31:24] = b;
          2'd1:    src_nxt[23:16] = b;
          2'd2:    src_nxt[15:8]  = b;
          default: src_nxt[7:0]   = b;
        endcase
      end
      if (pos == CW'(outer_len_nxt)) begin
        icmp_kind_nxt = b;
      end
      past_hdr    = pos >= CW'(outer_len_nxt) + CW'(OFS_ID_HI);
      inner_start = CW'(outer_len_nxt) + CW'(ICMP_HDR_LEN);
      if (past_hdr) begin
        if (is_echo) begin
          base   = CW'(outer_len_nxt);
          fld_en = 1'b1;
        end else if (is_te) begin
          if (pos == inner_start) begin
            inner_len_nxt = {b[3:0], 2'b00};
          end
          base   = inner_start + CW'(inner_len_nxt);
          fld_en = pos >= base + CW'(OFS_ID_HI);
        end
      end
      rel = pos - base;
      if (fld_en) begin
        if (rel == CW'(OFS_ID_HI)) begin
          seen_id_nxt[15:8] = b;
        end else if (rel == CW'(OFS_ID_LO)) begin
          seen_id_nxt[7:0] = b;
        end else if (rel == CW'(OFS_SEQ_HI)) begin
          seen_seq_nxt[15:8] = b;
        end else if (rel == CW'(OFS_SEQ_LO)) begin
          seen_seq_nxt[7:0] = b;
          found_nxt         = 1'b1;
        end
      end
    end
  end

  // Verdict, formed from the state as it stands after this byte.
  assign len      = {1'b0, count};
  assign fin_echo = icmp_kind_nxt == cfg.echo_reply_type;
  assign fin_te   = !fin_echo && icmp_kind_nxt == cfg.time_exceeded_type;

  always_comb begin
    res.reply_kind  = 1'b0;
    res.source_addr = src_nxt;
    res.round_trip  = item.now_ticks - cfg.send_time;
    if (len < CW'(outer_len_nxt) + CW'(ICMP_HDR_LEN)) begin
      res.outcome = OUTCOME_SHORT;
    end else begin
      res.reply_kind = fin_te;
      if (!fin_echo && !fin_te) begin
        res.outcome = OUTCOME_BAD_TYPE;
      end else if (!found_nxt) begin
        res.outcome = OUTCOME_SHORT;
      end else if (seen_id_nxt != cfg.expected_id || seen_seq_nxt != cfg.expected_seq) begin
        res.outcome = OUTCOME_MISMATCH;
      end else begin
        res.outcome = OUTCOME_MATCH;
      end
    end
  end

  assign res_valid      = step && item.last_byte;
  assign byte_index_nxt = count;

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      byte_index_r <= '0;
      outer_len_r  <= '0;
      icmp_kind_r  <= '0;
      inner_len_r  <= '0;
      seen_id_r    <= '0;
      seen_seq_r   <= '0;
      src_r        <= '0;
      found_r      <= 1'b0;
    end else if (step) begin
      byte_index_r <= byte_index_nxt;
      outer_len_r  <= outer_len_nxt;
      icmp_kind_r  <= icmp_kind_nxt;
      inner_len_r  <= inner_len_nxt;
      seen_id_r    <= seen_id_nxt;
      seen_seq_r   <= seen_seq_nxt;
      src_r        <= src_nxt;
      found_r      <= found_nxt;
    end
  end

endmodule

/* rtl/icmp_reply_matcher_top.sv */
// Top level of the ICMP reply matcher: input register, decoder core,
// result register and configuration port. Depends on icmp_rm_pkg.
//
// Usage: a received IPv4 packet is streamed in one byte per transfer on the
// in_ channel, with last_byte set on its final byte and now_ticks sampled
// there. For each packet exactly one result transfer appears on the out_
// channel: the outcome code, the reply kind, the outer source address and
// the round trip (now_ticks minus send_time, modulo 2^32).
// The input transfer is registered, decoded in a single pass of short logic
// and the verdict lands in the result register, so out_valid rises once the
// final byte has passed through the input register and the decoder, and the
// result transfers from there. One byte is taken per cycle, sustained; the
// only limit is the single result register.
// When the receiver stalls, a waiting result holds, and bytes that do not
// end a packet keep flowing; only a second final byte waits behind it.
// Bytes beyond MAX_PACKET_BYTES are counted as absent but still pass.
// The user writes the configuration registers over the APB-style port only
// while no packet is in flight; the block does not enforce this. Synchronous
// reset restores register defaults, clears packet state and both valid flags.
module icmp_reply_matcher_top
  import icmp_rm_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // Result channel.
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      advance;
  logic      res_valid;
  out_item_t res;
  cfg_t      cfg;

  icmp_rm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A registered byte moves into the decoder unless it ends a packet while
  // the result register is still held by a stalled receiver.
  assign advance  = in_valid_r &&
                    !(in_data_r.last_byte && out_valid_r && out_stall);
  assign in_stall = in_valid_r && !advance;

  icmp_rm_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_data_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // The input register refills in the same cycle that it drains.
  assign in_valid_nxt  = (in_valid_r && !advance) || in_valid;
  assign out_valid_nxt = res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/icmp_rm_checker.sv */
`timescale 1ns / 1ps
// Checker for the ICMP reply matcher: watches the configuration port and both
// channels, predicts each packet's verdict and compares it field by field.
// Depends on icmp_rm_pkg.
module icmp_rm_checker
  import icmp_rm_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                results_due
);

  // Shadow of the configuration registers.
  logic [15:0] want_id;
  logic [15:0] want_seq;
  logic [7:0]  echo_code;
  logic [7:0]  te_code;
  logic [31:0] probe_time;

  // Per-packet decode state.
  logic [10:0] byte_count;
  logic [5:0]  hdr_len;
  logic [5:0]  quote_len;
  logic [7:0]  type_seen;
  logic [15:0] got_id;
  logic [15:0] got_seq;
  logic [31:0] src_addr;
  logic        ids_done;

  out_item_t verdicts_due[$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic clear_packet();
    byte_count = '0;
    hdr_len    = '0;
    quote_len  = '0;
    type_seen  = '0;
    got_id     = '0;
    got_seq    = '0;
    src_addr   = '0;
    ids_done   = 1'b0;
  endtask

  // Id and sequence bytes sit at fixed offsets from the start of whichever
  // ICMP header carries them.
  task automatic grab_id_seq(int unsigned rel, logic [7:0] b);
    case (rel)
      OFS_ID_HI:  got_id[15:8] = b;
      OFS_ID_LO:  got_id[7:0] = b;
      OFS_SEQ_HI: got_seq[15:8] = b;
      OFS_SEQ_LO: begin
        got_seq[7:0] = b;
        ids_done = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic track_byte(int unsigned pos, logic [7:0] b);
    int unsigned quote_start;
    if (pos == 0) hdr_len = {b[3:0], 2'b00};
    if (pos >= SRC_FIRST && pos <= SRC_LAST) src_addr[(SRC_LAST - pos) * 8 +: 8] = b;
    if (pos == hdr_len) type_seen = b;
    if (pos >= hdr_len + OFS_ID_HI) begin
      if (type_seen == echo_code) begin
        grab_id_seq(pos - hdr_len, b);
      end else if (type_seen == te_code) begin
        quote_start = hdr_len + ICMP_HDR_LEN;
        if (pos == quote_start) quote_len = {b[3:0], 2'b00};
        if (pos >= quote_start + quote_len + OFS_ID_HI)
          grab_id_seq(pos - (quote_start + quote_len), b);
      end
    end
  endtask

  task automatic take_transfer(in_item_t it);
    out_item_t v;
    logic      is_echo;
    logic      is_te;
    if (byte_count < MAX_BYTES) begin
      track_byte(byte_count, it.data_byte);
      byte_count++;
    end
    if (it.last_byte) begin
      is_echo      = (type_seen == echo_code);
      is_te        = !is_echo && (type_seen == te_code);
      v.reply_kind = 1'b0;
      if (byte_count < hdr_len + ICMP_HDR_LEN) begin
        v.outcome = OUTCOME_SHORT;
      end else begin
        v.reply_kind = is_te;
        if (!is_echo && !is_te) v.outcome = OUTCOME_BAD_TYPE;
        else if (!ids_done) v.outcome = OUTCOME_SHORT;
        else if (got_id != want_id || got_seq != want_seq) v.outcome = OUTCOME_MISMATCH;
        else v.outcome = OUTCOME_MATCH;
      end
      v.source_addr = src_addr;
      v.round_trip  = it.now_ticks - probe_time;
      verdicts_due.push_back(v);
      clear_packet();
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (verdicts_due.size() == 0) begin
      report("result without a finished packet", 32'(got.outcome), 32'd0);
      return;
    end
    want = verdicts_due.pop_front();
    if (got.outcome !== want.outcome)
      report("outcome", 32'(got.outcome), 32'(want.outcome));
    if (got.reply_kind !== want.reply_kind)
      report("reply_kind", 32'(got.reply_kind), 32'(want.reply_kind));
    if (got.source_addr !== want.source_addr)
      report("source_addr", got.source_addr, want.source_addr);
    if (got.round_trip !== want.round_trip)
      report("round_trip", got.round_trip, want.round_trip);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_id    = '0;
      want_seq   = '0;
      echo_code  = '0;
      te_code    = TE_TYPE_RESET;
      probe_time = '0;
      clear_packet();
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_EXPECTED_ID:  want_id = pwdata[15:0];
          REG_EXPECTED_SEQ: want_seq = pwdata[15:0];
          REG_ECHO_TYPE:    echo_code = pwdata[7:0];
          REG_TE_TYPE:      te_code = pwdata[7:0];
          REG_SEND_TIME:    probe_time = pwdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) take_transfer(in_data);
    end
    results_due <= verdicts_due.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Top of the ICMP reply matcher testbench: clock, reset, register programming
// and packet stimulus. Depends on icmp_rm_pkg, icmp_reply_matcher_top and
// icmp_rm_checker.
module tb_top;
  import icmp_rm_pkg::*;

  localparam int unsigned MAX_BYTES    = 128;
  localparam int unsigned PERIOD       = 12;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int results_due;

  // Our own copy of the register values, used only to shape packets so that
  // most of them get past the type check and reach the id and sequence fields.
  logic [15:0] exp_id     = '0;
  logic [15:0] exp_seq    = '0;
  logic [7:0]  echo_code  = '0;
  logic [7:0]  te_code    = TE_TYPE_RESET;
  logic [31:0] probe_time = '0;

  // Idle rates in percent: the sender leaves gaps, the receiver stalls.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // One long receiver hold-off, requested once from the stimulus.
  logic        hold_req   = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left  = 0;

  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned pkts_sent   = 0;

  logic [7:0] frame_q[$];

  always #(PERIOD / 2) clk = ~clk;

  icmp_reply_matcher_top #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  icmp_rm_checker #(
    .MAX_BYTES(MAX_BYTES)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  // Watchdog. A result that never arrives keeps the stimulus waiting, and
  // this is what ends such a run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver. Normally it stalls at the current random rate; once the hold-off
  // is requested it refuses every result for a long stretch, so that the
  // single result register fills and the block has to stall its input.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // A register write has a setup phase and then an access phase; the register
  // takes the value at the edge that ends the access phase.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] id_w, logic [15:0] seq_w, logic [7:0] echo_w,
                              logic [7:0] te_w, logic [31:0] sent_w);
    exp_id     = id_w;
    exp_seq    = seq_w;
    echo_code  = echo_w;
    te_code    = te_w;
    probe_time = sent_w;
    write_reg(REG_EXPECTED_ID, {16'h0, id_w});
    write_reg(REG_EXPECTED_SEQ, {16'h0, seq_w});
    write_reg(REG_ECHO_TYPE, {24'h0, echo_w});
    write_reg(REG_TE_TYPE, {24'h0, te_w});
    write_reg(REG_SEND_TIME, sent_w);
  endtask

  // The tick value travels on every byte but only matters on the last one;
  // the extremes and the send time itself come up often.
  function automatic logic [31:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 20) return 32'hFFFF_FFFF;
    if (r < 30) return probe_time;
    return $urandom;
  endfunction

  // Mostly correct id and sequence; otherwise one or both get a flipped bit.
  function automatic int unsigned id_fault();
    if ($urandom_range(0, 99) < 60) return 0;
    return $urandom_range(1, 3);
  endfunction

  // One byte transfer. Gaps come before the byte is offered; once offered, it
  // and its valid stay put until the block takes them.
  task automatic push_byte(logic [7:0] b, logic fin, logic [31:0] ticks);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: fin, now_ticks: ticks};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1, pick_ticks());
    pkts_sent++;
  endtask

  // Builds a well-formed reply around random filler. For a time-exceeded
  // message the id and sequence go into the ICMP header behind the quoted
  // inner IP header. With a header length below five words the fields land
  // on top of the IP header; the decoder reads them the same way.
  task automatic build_reply(bit want_te, int unsigned ihl, int unsigned inner_ihl,
                             int unsigned fault, int unsigned pay_len);
    int unsigned ofs;
    int unsigned fld;
    logic [15:0] id_w;
    logic [15:0] seq_w;
    ofs   = ihl * 4;
    fld   = want_te ? ofs + ICMP_HDR_LEN + inner_ihl * 4 : ofs;
    id_w  = exp_id;
    seq_w = exp_seq;
    if (fault == 1 || fault == 3) id_w = id_w ^ (16'h1 << $urandom_range(0, 15));
    if (fault == 2 || fault == 3) seq_w = seq_w ^ (16'h1 << $urandom_range(0, 15));
    frame_q = {};
    repeat (fld + ICMP_HDR_LEN + pay_len) frame_q.push_back(8'($urandom));
    frame_q[0]   = {4'h4, 4'(ihl)};
    frame_q[ofs] = want_te ? te_code : echo_code;
    if (want_te) frame_q[ofs + ICMP_HDR_LEN] = {4'h4, 4'(inner_ihl)};
    frame_q[fld + OFS_ID_HI]  = id_w[15:8];
    frame_q[fld + OFS_ID_LO]  = id_w[7:0];
    frame_q[fld + OFS_SEQ_HI] = seq_w[15:8];
    frame_q[fld + OFS_SEQ_LO] = seq_w[7:0];
  endtask

  task automatic trim_to(int unsigned n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  task automatic noise_packet(int unsigned n);
    frame_q = {};
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // An echo-shaped packet whose type byte matches neither code.
  task automatic build_odd_type(int unsigned ihl);
    logic [7:0] odd;
    build_reply(1'b0, ihl, 0, 0, $urandom_range(0, 8));
    do odd = 8'($urandom); while (odd == echo_code || odd == te_code);
    frame_q[ihl * 4] = odd;
  endtask

  task automatic random_packet();
    int unsigned pick;
    int unsigned ihl;
    int unsigned inner_ihl;
    pick      = $urandom_range(0, 99);
    ihl       = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(6, 15);
    inner_ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
    if (pick < 35) begin
      build_reply(1'b0, ihl, 0, id_fault(), $urandom_range(0, 8));
    end else if (pick < 65) begin
      build_reply(1'b1, ihl, inner_ihl, id_fault(), $urandom_range(0, 8));
    end else if (pick < 75) begin
      build_reply(1'($urandom_range(0, 1)), ihl, inner_ihl, 0, 0);
      trim_to($urandom_range(1, frame_q.size() - 1));
    end else if (pick < 85) begin
      build_odd_type(ihl);
    end else if (pick < 95) begin
      noise_packet($urandom_range(1, 40));
    end else begin
      build_reply(1'($urandom_range(0, 1)), $urandom_range(0, 4), $urandom_range(0, 4),
                  id_fault(), $urandom_range(0, 8));
    end
    send_packet();
  endtask

  task automatic random_traffic(int unsigned min_bytes, int unsigned min_pkts);
    int unsigned b0;
    int unsigned p0;
    b0 = bytes_sent;
    p0 = pkts_sent;
    while (bytes_sent - b0 < min_bytes || pkts_sent - p0 < min_pkts) random_packet();
  endtask

  // Waits until every finished packet has had its verdict and the bytes still
  // inside the block have settled, before any register changes.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned gap, int unsigned stall);
    gap_pct = gap;
    stall_pct <= stall;
  endtask

  function automatic logic [7:0] other_code(logic [7:0] code);
    logic [7:0] c;
    c = 8'($urandom);
    if (c == code) c = c ^ 8'h01;
    return c;
  endfunction

  initial begin
    logic [7:0] te_pick;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets at the register reset values, with no idling.
    frame_q = '{8'hFF};
    send_packet();                              // single byte, far too short
    frame_q = '{8'h00};
    send_packet();
    build_reply(1'b0, 5, 0, 0, 0);              // echo reply that matches
    send_packet();
    build_reply(1'b0, 5, 0, 1, 0);              // id differs
    send_packet();
    build_reply(1'b0, 5, 0, 2, 0);              // sequence differs
    send_packet();
    build_reply(1'b1, 5, 5, 0, 0);              // time exceeded that matches
    send_packet();
    build_reply(1'b1, 5, 5, 0, 0);              // past the outer ICMP header,
    trim_to(20 + ICMP_HDR_LEN + 10);            // but the inner id never comes
    send_packet();
    build_odd_type(5);
    send_packet();
    build_reply(1'b0, 1, 0, 0, 0);              // ICMP header inside IP header
    send_packet();
    build_reply(1'b0, 0, 0, 0, 0);              // zero header length
    send_packet();
    random_traffic(80, 2);

    // Extremes of the match words and of the send time; sender gaps.
    settle();
    program_regs(16'hFFFF, 16'hFFFF, 8'd0, TE_TYPE_RESET, 32'hFFFF_FFFF);
    set_idling(51, 0);
    random_traffic(80, 2);

    // Opposite extremes of every register; receiver stalls.
    settle();
    program_regs(16'h0000, 16'h0000, 8'hFF, 8'h00, 32'h0);
    set_idling(0, 51);
    random_traffic(80, 2);

    // Random match words with the usual type codes; light idling on both sides.
    settle();
    program_regs(16'($urandom), 16'($urandom), 8'd0, TE_TYPE_RESET, $urandom);
    set_idling(11, 11);
    random_traffic(80, 2);

    // Back pressure: the receiver holds off while short packets keep coming,
    // so a second verdict queues behind the first and the input stalls.
    settle();
    te_pick = 8'($urandom);
    program_regs(16'($urandom), 16'($urandom), other_code(te_pick), te_pick, $urandom);
    set_idling(0, 0);
    hold_req <= 1'b1;
    repeat (25) begin
      noise_packet($urandom_range(1, 3));
      send_packet();
    end
    random_traffic(60, 2);

    // Both type codes equal, so the echo path wins; one packet runs past the
    // size limit and its tail is ignored.
    settle();
    te_pick = 8'($urandom);
    program_regs(16'($urandom), 16'($urandom), te_pick, te_pick, $urandom);
    set_idling(51, 0);
    build_reply(1'b0, 5, 0, 0, MAX_BYTES - 20 + $urandom_range(0, 12));
    send_packet();
    random_traffic(80, 2);

    settle();
    te_pick = 8'($urandom);
    program_regs(16'($urandom), 16'($urandom), other_code(te_pick), te_pick, $urandom);
    set_idling(11, 11);
    random_traffic(80, 2);

    settle();
    program_regs(16'($urandom), 16'($urandom), 8'd0, 8'hFF, $urandom);
    set_idling(0, 51);
    random_traffic(80, 2);

    settle();
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
rtl/icmp_rm_pkg.sv
rtl/icmp_rm_cfg.sv
rtl/icmp_rm_core.sv
rtl/icmp_reply_matcher_top.sv
verif/icmp_rm_checker.sv
verif/tb_top.sv
